// ===== rtl/xalu_pkg.sv =====
package xalu_pkg;

  localparam int unsigned DataWidth = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_OR  = 3'd1,
    CMD_ADC = 3'd2,
    CMD_SBB = 3'd3,
    CMD_AND = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2,
    SIZE_64 = 2'd3
  } size_e;

  typedef struct packed {
    logic [2:0]           command;
    logic [1:0]           op_size;
    logic [DataWidth-1:0] dest_value;
    logic [DataWidth-1:0] src_value;
    logic                 carry_in;
  } in_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 carry_flag;
    logic                 parity_flag;
    logic                 adjust_flag;
    logic                 zero_flag;
    logic                 sign_flag;
    logic                 overflow_flag;
  } res_t;

  // Keep the bits of the operand size, clear the rest.
  function automatic logic [DataWidth-1:0] size_mask(logic [1:0] sz);
    logic [DataWidth-1:0] m;
    unique case (sz)
      SIZE_8:  m = {{(DataWidth-8){1'b0}}, {8{1'b1}}};
      SIZE_16: m = {{(DataWidth-16){1'b0}}, {16{1'b1}}};
      SIZE_32: m = {{(DataWidth-32){1'b0}}, {32{1'b1}}};
      SIZE_64: m = {DataWidth{1'b1}};
      default: m = {DataWidth{1'b1}};
    endcase
    return m;
  endfunction

  // Most significant bit of the sized word.
  function automatic logic sign_bit(logic [DataWidth-1:0] v, logic [1:0] sz);
    logic s;
    unique case (sz)
      SIZE_8:  s = v[7];
      SIZE_16: s = v[15];
      SIZE_32: s = v[31];
      SIZE_64: s = v[63];
      default: s = v[63];
    endcase
    return s;
  endfunction

  // Bit just above the sized word: carry out of an add, borrow of a subtract.
  function automatic logic carry_bit(logic [DataWidth:0] v, logic [1:0] sz);
    logic c;
    unique case (sz)
      SIZE_8:  c = v[8];
      SIZE_16: c = v[16];
      SIZE_32: c = v[32];
      SIZE_64: c = v[64];
      default: c = v[64];
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/xalu_exec.sv =====
module xalu_exec (
  input  xalu_pkg::in_t  op_i,
  output xalu_pkg::res_t res_o
);

  logic [xalu_pkg::DataWidth-1:0] mask;
  logic [xalu_pkg::DataWidth-1:0] a;
  logic [xalu_pkg::DataWidth-1:0] b;
  logic [xalu_pkg::DataWidth-1:0] r;
  logic [xalu_pkg::DataWidth:0]   sum;
  logic [xalu_pkg::DataWidth:0]   dif;
  logic                           add_c;
  logic                           valid_cmd;
  logic                           cf;
  logic                           af;
  logic                           of;

  always_comb begin
    mask  = xalu_pkg::size_mask(op_i.op_size);
    a     = op_i.dest_value & mask;
    b     = op_i.src_value & mask;
    add_c = (op_i.command == xalu_pkg::CMD_ADC) ? op_i.carry_in : 1'b0;
    sum   = {1'b0, a} + {1'b0, b} + {{xalu_pkg::DataWidth{1'b0}}, add_c};
    dif   = {1'b0, a} - {1'b0, b} - {{xalu_pkg::DataWidth{1'b0}}, op_i.carry_in};

    r         = '0;
    cf        = 1'b0;
    af        = 1'b0;
    of        = 1'b0;
    valid_cmd = 1'b1;
    unique case (op_i.command) inside
      xalu_pkg::CMD_ADD, xalu_pkg::CMD_ADC: begin
        r  = sum[xalu_pkg::DataWidth-1:0] & mask;
        cf = xalu_pkg::carry_bit(sum, op_i.op_size);
        af = a[4] ^ b[4] ^ r[4];
        of = xalu_pkg::sign_bit((a ^ r) & (b ^ r), op_i.op_size);
      end
      xalu_pkg::CMD_SBB: begin
        r  = dif[xalu_pkg::DataWidth-1:0] & mask;
        cf = xalu_pkg::carry_bit(dif, op_i.op_size);
        af = a[4] ^ b[4] ^ r[4];
        of = xalu_pkg::sign_bit((a ^ b) & (a ^ r), op_i.op_size);
      end
      xalu_pkg::CMD_OR: begin
        r = a | b;
      end
      xalu_pkg::CMD_AND: begin
        r = a & b;
      end
      default: begin
        valid_cmd = 1'b0;
      end
    endcase

    // Unused command codes return an all-zero word.
    res_o.result        = r;
    res_o.carry_flag    = cf;
    res_o.parity_flag   = valid_cmd & ~(^r[7:0]);
    res_o.adjust_flag   = af;
    res_o.zero_flag     = valid_cmd & (r == '0);
    res_o.sign_flag     = xalu_pkg::sign_bit(r, op_i.op_size);
    res_o.overflow_flag = of;
  end

endmodule

// ===== rtl/x86_integer_alu_add_logic_core.sv =====
// Integer ALU for ADD, OR, ADC, SBB and AND on 8, 16, 32 or 64-bit operands,
// giving the sized result together with CF, PF, AF, ZF, SF and OF.
//
// Input channel: drive an operand word on in_i and raise start_i. The word
// is taken at the rising edge where start_i is high and busy_o is low.
// busy_o stays low: the ALU never stalls and takes a word every cycle.
//
// Result channel: done_o is high for exactly one cycle while res_o carries
// the result word; the receiver takes it at the edge that ends that cycle.
// There is no backpressure, so a word is never held or dropped.
//
// Path: a taken word lands in the operand register, passes the single
// adder/logic pass, and is registered into the result register, which
// raises done_o along with it.
// Throughput: one word per cycle, bounded by the 65-bit add/subtract.
//
// Reset (rst_ni low, asynchronous): clear both valid flags so no result is
// shown until a new word is taken; the payload registers are not reset.
module x86_integer_alu_add_logic_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  xalu_pkg::in_t  in_i,
  output logic           done_o,
  output xalu_pkg::res_t res_o
);

  xalu_pkg::in_t  op_q;
  logic           op_valid_q;
  xalu_pkg::res_t res_d;
  xalu_pkg::res_t res_q;
  logic           done_q;
  logic           accept;

  // Never stall the sender.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Operand register: capture each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else begin
      op_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i;
    end
  end

  xalu_exec u_exec (
    .op_i  (op_q),
    .res_o (res_d)
  );

  // Result register: advance the strobe with the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A result strobe is raised in the cycle after the operand register holds a word.
  a_done_follows_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(op_valid_q)))
    else $error("result strobe does not follow operand register");

  // Logic operations never raise the arithmetic flags.
  a_logic_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.carry_flag || res_o.adjust_flag || res_o.overflow_flag))
      |-> ($past(op_q.command) == xalu_pkg::CMD_ADD ||
           $past(op_q.command) == xalu_pkg::CMD_ADC ||
           $past(op_q.command) == xalu_pkg::CMD_SBB))
    else $error("arithmetic flag set by a non-arithmetic command");

  // Byte results keep the upper bits clear.
  a_byte_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(op_q.op_size) == xalu_pkg::SIZE_8)
      |-> (res_o.result[xalu_pkg::DataWidth-1:8] == '0))
    else $error("byte result has upper bits set");

  // A set zero flag means a zero result.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.zero_flag) |-> (res_o.result == '0))
    else $error("zero flag set on a nonzero result");

endmodule
